[design/knn_classifier_top_assert.svh]
// Assertion macros shared by the classifier RTL files.
`ifndef KNN_CLASSIFIER_TOP_ASSERT_SVH
`define KNN_CLASSIFIER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked at every clock edge while reset is released.
`define KNN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("knn assertion failed");
// Checked at every clock edge, reset included.
`define KNN_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("knn assertion failed");
`else
`define KNN_ASSERT(lbl, prop)
`define KNN_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

[design/knn_pkg.sv]
// Shared types and constants of the nearest-neighbour classifier.
`default_nettype none
package knn_pkg;
  localparam int unsigned FEAT_W  = 8;
  localparam int unsigned LABEL_W = 8;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned CFG_W   = 4;
  localparam int unsigned NUM_IN_FEAT = 7;

  localparam logic REQ_STORE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic CFG_K_NEIGHBOURS   = 1'b0;
  localparam logic CFG_ACTIVE_RECORDS = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_ACC,
    S_SQRT,
    S_INS,
    S_VOTE,
    S_DONE
  } state_e;
endpackage
`default_nettype wire

[design/knn_isqrt.sv]
// Iterative integer square root, one result bit per cycle.
`default_nettype none
module knn_isqrt #(
  parameter int unsigned SUM_W = 19
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [SUM_W-1:0]           operand_i,
  output logic                            done_o,
  output logic [(SUM_W+1)/2-1:0]          root_o
);
  import knn_pkg::*;

  localparam int unsigned ITER   = (SUM_W + 1) / 2;
  localparam int unsigned ROOT_W = ITER;

  logic [SUM_W-1:0] v_q, v_d, res_q, res_d, bit_q, bit_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [SUM_W:0]   trial;

  assign trial = {1'b0, res_q} + {1'b0, bit_q};

  always_comb begin
    v_d    = v_q;
    res_d  = res_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      v_d    = operand_i;
      res_d  = '0;
      bit_d  = SUM_W'(1) << (2 * (ITER - 1));
      busy_d = 1'b1;
    end else if (busy_q) begin
      if ({1'b0, v_q} >= trial) begin
        v_d   = v_q - trial[SUM_W-1:0];
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[ROOT_W-1:0];

`include "knn_classifier_top_assert.svh"
  `KNN_ASSERT(a_bit_onehot, busy_q |-> $onehot(bit_q))
  `KNN_ASSERT(a_done_after_busy, done_q |-> $past(busy_q) && !busy_q)
  `KNN_ASSERT(a_start_when_free, start_i |-> !busy_q)
  `KNN_ASSERT_ALWAYS(a_reset_free, !rst_ni |=> !busy_q || start_i)
endmodule
`default_nettype wire

[design/knn_classifier_top.sv]
// Top level of the k-nearest-neighbour classifier.
// Usage:
// The input channel carries one transaction per request. A store request
// (req_type 0) writes seven features and a label into the record memory slot
// given by record_slot and produces no result. A query
// (req_type 1) compares its features with records 0 to n-1 and produces one
// result transaction with the winning class and its vote count.
// A query runs n passes, each of one memory read, squared-difference
// accumulation over the features, a run of the iterative square root unit
// and a sorted insertion, then a voting pass over the k nearest records and
// a load of the output register.
// Stores are accepted only while no query is running.
// The result sits in an output register; the next request is accepted while
// a result waits, and a finished query holds in its final state until the
// receiver has taken the previous result.
// Reset clears the control state and sets k to 2 and the active count to 6;
// the record memory is not cleared and must be written before it is queried.
`default_nettype none
module knn_classifier_top #(
  parameter int unsigned MAX_RECORDS  = 8,
  parameter int unsigned NUM_FEATURES = 7
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_index_i,
  input  wire logic [knn_pkg::CFG_W-1:0]    cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         req_type_i,
  input  wire logic [knn_pkg::SLOT_W-1:0]   record_slot_i,
  input  wire logic [knn_pkg::FEAT_W-1:0]   feature_0_i,
  input  wire logic [knn_pkg::FEAT_W-1:0]   feature_1_i,
  input  wire logic [knn_pkg::FEAT_W-1:0]   feature_2_i,
  input  wire logic [knn_pkg::FEAT_W-1:0]   feature_3_i,
  input  wire logic [knn_pkg::FEAT_W-1:0]   feature_4_i,
  input  wire logic [knn_pkg::FEAT_W-1:0]   feature_5_i,
  input  wire logic [knn_pkg::FEAT_W-1:0]   feature_6_i,
  input  wire logic [knn_pkg::LABEL_W-1:0]  label_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [knn_pkg::LABEL_W-1:0]       predicted_class_o,
  output logic [knn_pkg::CNT_W-1:0]         winning_votes_o
);
  import knn_pkg::*;

  localparam int unsigned AW     = $clog2(MAX_RECORDS);
  localparam int unsigned SW     = (AW + 1 > SLOT_W) ? AW + 1 : SLOT_W;
  localparam int unsigned RW     = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;
  localparam int unsigned FW     = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
  localparam int unsigned SUM_W  = $clog2(NUM_FEATURES * 65025 + 1);
  localparam int unsigned DIST_W = (SUM_W + 1) / 2;
  localparam int unsigned MEM_W  = NUM_FEATURES * FEAT_W + LABEL_W;
  localparam int unsigned KMAX   = (MAX_RECORDS < 15) ? MAX_RECORDS : 15;
  localparam int unsigned KIW    = $clog2(KMAX);
  localparam int unsigned LCW    = $clog2(KMAX + 1);

  // Record memory: features packed low, label on top.
  logic [MEM_W-1:0] rec_mem [MAX_RECORDS];
  logic [MEM_W-1:0] rd_data_q;
  logic [MEM_W-1:0] wr_data;
  logic [AW-1:0]    rd_addr;
  logic             mem_we;
  logic [SW-1:0]    slot_ext;

  logic [FEAT_W-1:0] in_feat [NUM_IN_FEAT];
  logic [FEAT_W-1:0] q_feat_q [NUM_FEATURES];

  state_e state_q, state_d;
  logic [CNT_W-1:0] k_cfg_q, n_cfg_q;
  logic [CNT_W-1:0] n_q, k_q, n_sat, k_sat;
  logic [AW-1:0]    r_q;
  logic [FW-1:0]    f_q;
  logic [SUM_W-1:0] sum_q, sum_next;
  logic [FEAT_W-1:0] qa, rb, diff;
  logic [2*FEAT_W-1:0] sq;
  logic             in_acc;
  logic             last_feat, last_rec, last_vote;

  // Sorted list of the nearest records seen so far.
  logic [DIST_W-1:0]  dist_q [KMAX];
  logic [LABEL_W-1:0] lab_q  [KMAX];
  logic [LCW-1:0]     list_cnt_q;
  logic [KMAX-1:0]    le;
  logic [LABEL_W-1:0] rec_label;

  logic [KIW-1:0]     i_q;
  logic [KMAX-1:0]    match;
  logic [CNT_W-1:0]   votes;
  logic [CNT_W-1:0]   best_votes_q;
  logic [LABEL_W-1:0] best_class_q;
  logic [LABEL_W-1:0] out_class_q;
  logic [CNT_W-1:0]   out_votes_q;
  logic               out_valid_q;
  logic               out_load;

  logic               sqrt_start, sqrt_done;
  logic [DIST_W-1:0]  sqrt_root;

  assign in_feat[0] = feature_0_i;
  assign in_feat[1] = feature_1_i;
  assign in_feat[2] = feature_2_i;
  assign in_feat[3] = feature_3_i;
  assign in_feat[4] = feature_4_i;
  assign in_feat[5] = feature_5_i;
  assign in_feat[6] = feature_6_i;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    for (int f = 0; f < NUM_FEATURES; f++) begin
      wr_data[f*FEAT_W +: FEAT_W] = in_feat[f];
    end
    wr_data[NUM_FEATURES*FEAT_W +: LABEL_W] = label_i;
  end

  // Reads happen only while a query runs and writes only while idle, so an
  // entry is never read and written in the same cycle.
  assign slot_ext = SW'(record_slot_i);
  assign mem_we   = in_acc && (req_type_i == REQ_STORE) && (slot_ext < SW'(MAX_RECORDS));
  assign rd_addr  = r_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rec_mem[slot_ext[AW-1:0]] <= wr_data;
    end
    if (state_q == S_RD) begin
      rd_data_q <= rec_mem[rd_addr];
    end
  end

  // Saturated record and neighbour counts, latched at the start of a query.
  always_comb begin
    if (n_cfg_q == '0) begin
      n_sat = CNT_W'(1);
    end else if (RW'(n_cfg_q) > RW'(MAX_RECORDS)) begin
      n_sat = CNT_W'(MAX_RECORDS);
    end else begin
      n_sat = n_cfg_q;
    end
    if (k_cfg_q == '0) begin
      k_sat = CNT_W'(1);
    end else if (k_cfg_q > n_sat) begin
      k_sat = n_sat;
    end else begin
      k_sat = k_cfg_q;
    end
  end

  // One squared feature difference per cycle.
  assign qa       = q_feat_q[f_q];
  assign rb       = rd_data_q[f_q*FEAT_W +: FEAT_W];
  assign diff     = (qa > rb) ? (qa - rb) : (rb - qa);
  assign sq       = diff * diff;
  assign sum_next = sum_q + SUM_W'(sq);
  assign rec_label = rd_data_q[NUM_FEATURES*FEAT_W +: LABEL_W];

  assign last_feat  = (f_q == FW'(NUM_FEATURES - 1));
  assign last_rec   = (RW'(r_q) == RW'(n_q) - RW'(1));
  assign last_vote  = (CNT_W'(i_q) == k_q - CNT_W'(1));
  assign sqrt_start = (state_q == S_ACC) && last_feat;

  knn_isqrt #(
    .SUM_W(SUM_W)
  ) u_isqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (sqrt_start),
    .operand_i(sum_next),
    .done_o   (sqrt_done),
    .root_o   (sqrt_root)
  );

  // Entries at or below the new distance stay ahead of it, which keeps
  // equal distances in record order.
  always_comb begin
    for (int j = 0; j < KMAX; j++) begin
      le[j] = (LCW'(j) < list_cnt_q) && (dist_q[j] <= sqrt_root);
    end
  end

  always_comb begin
    for (int j = 0; j < KMAX; j++) begin
      match[j] = (CNT_W'(j) < k_q) && (lab_q[j] == lab_q[i_q]);
    end
    votes = CNT_W'($countones(match));
  end

  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (req_type_i == REQ_QUERY)) begin
          state_d = S_RD;
        end
      end
      S_RD:   state_d = S_ACC;
      S_ACC: begin
        if (last_feat) begin
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sqrt_done) begin
          state_d = S_INS;
        end
      end
      S_INS:  state_d = last_rec ? S_VOTE : S_RD;
      S_VOTE: begin
        if (last_vote) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_cfg_q     <= CNT_W'(2);
      n_cfg_q     <= CNT_W'(6);
      out_valid_q <= 1'b0;
      list_cnt_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_K_NEIGHBOURS) begin
          k_cfg_q <= cfg_data_i;
        end else begin
          n_cfg_q <= cfg_data_i;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_IDLE) begin
        list_cnt_q <= '0;
      end else if ((state_q == S_INS) && (list_cnt_q != LCW'(KMAX))) begin
        list_cnt_q <= list_cnt_q + LCW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        for (int f = 0; f < NUM_FEATURES; f++) begin
          q_feat_q[f] <= in_feat[f];
        end
        n_q <= n_sat;
        k_q <= k_sat;
        r_q <= '0;
      end
      S_RD: begin
        f_q   <= '0;
        sum_q <= '0;
      end
      S_ACC: begin
        f_q   <= f_q + FW'(1);
        sum_q <= sum_next;
      end
      S_INS: begin
        for (int j = 0; j < KMAX; j++) begin
          if (!le[j]) begin
            if (j == 0) begin
              dist_q[j] <= sqrt_root;
              lab_q[j]  <= rec_label;
            end else if (le[(j == 0) ? 0 : j-1]) begin
              dist_q[j] <= sqrt_root;
              lab_q[j]  <= rec_label;
            end else begin
              dist_q[j] <= dist_q[(j == 0) ? 0 : j-1];
              lab_q[j]  <= lab_q[(j == 0) ? 0 : j-1];
            end
          end
        end
        r_q          <= r_q + AW'(1);
        i_q          <= '0;
        best_votes_q <= '0;
        best_class_q <= '0;
      end
      S_VOTE: begin
        // A later copy of a class has the same count, so only its first
        // appearance in sorted order can win.
        if (votes > best_votes_q) begin
          best_votes_q <= votes;
          best_class_q <= lab_q[i_q];
        end
        i_q <= i_q + KIW'(1);
      end
      S_DONE: begin
        if (out_load) begin
          out_class_q <= best_class_q;
          out_votes_q <= best_votes_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign predicted_class_o = out_class_q;
  assign winning_votes_o   = out_votes_q;

`include "knn_classifier_top_assert.svh"
  `KNN_ASSERT(a_list_bound, list_cnt_q <= LCW'(KMAX))
  `KNN_ASSERT(a_root_in_sqrt, sqrt_done |-> state_q == S_SQRT)
  `KNN_ASSERT(a_result_from_done, out_load |=> out_valid_q && state_q == S_IDLE)
  `KNN_ASSERT(a_no_write_busy, mem_we |-> state_q == S_IDLE)
endmodule
`default_nettype wire
